// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shorthand for clocked concurrent assertions used by the mask pipeline
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define EBFM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define EBFM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: sv/ebfm_pkg.sv
// ----------------------------------------------------------------------------
// ebfm_pkg
// shared widths, codes and types of the elliptical fade mask pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package ebfm_pkg;

   localparam int COORD_W     = 16;
   localparam int OCOEF_W     = 18;
   localparam int FCOEF_W     = 24;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int MAG_W       = 16;
   localparam int PO_W        = MAG_W + OCOEF_W;
   localparam int PF_W        = MAG_W + FCOEF_W;
   localparam int SQO_W       = 2 * PO_W;
   localparam int SQF_W       = 2 * PF_W;
   localparam int N_W         = SQO_W + 1;
   localparam int NF_W        = SQF_W + 1;
   localparam int QUOT_BITS   = 8;
   localparam int REM_W       = NF_W + QUOT_BITS;
   localparam int MASK_W      = 8;

   localparam int DEF_COORD_FRAC_BITS = 4;
   localparam int DEF_COEF_FRAC_BITS  = 16;

   localparam logic [OCOEF_W-1:0] RESET_OUTER_COEF = OCOEF_W'(2048);
   localparam logic [FCOEF_W-1:0] RESET_FADE_COEF  = FCOEF_W'(2048);

   localparam logic [MASK_W-1:0] MASK_FULL  = '1;
   localparam logic [MASK_W-1:0] MASK_CLEAR = '0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_OUTER_X = 3'd0,
      REG_OUTER_Y = 3'd1,
      REG_FADE_X  = 3'd2,
      REG_FADE_Y  = 3'd3
   } reg_index_type;

   typedef struct packed {
      logic outside;
      logic core;
      logic flat;
   } band_type;

   typedef struct packed {
      logic [N_W-1:0]  n;
      logic [NF_W-1:0] nf;
   } norm_type;

   typedef struct packed {
      band_type         band;
      logic [REM_W-1:0] rem;
      logic [NF_W-1:0]  den;
   } quot_type;

endpackage

`default_nettype wire

// File: sv/ebfm_norm.sv
// ----------------------------------------------------------------------------
// ebfm_norm
// four stage squared norms of the outer and fade ellipses
// ----------------------------------------------------------------------------
`default_nettype none

module ebfm_norm (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic signed [ebfm_pkg::COORD_W-1:0] offset_x,
   input  wire logic signed [ebfm_pkg::COORD_W-1:0] offset_y,
   input  wire logic [ebfm_pkg::OCOEF_W-1:0]  outer_x_coef,
   input  wire logic [ebfm_pkg::OCOEF_W-1:0]  outer_y_coef,
   input  wire logic [ebfm_pkg::FCOEF_W-1:0]  fade_x_coef,
   input  wire logic [ebfm_pkg::FCOEF_W-1:0]  fade_y_coef,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output ebfm_pkg::norm_type                 out_data
);
   import ebfm_pkg::*;

   localparam int L  = 4;
   localparam int OH = PO_W / 2;
   localparam int FH = PF_W / 2;

   logic [L-1:0] v_ff, v_in, en;

   logic [MAG_W-1:0] mag_x, mag_y;
   logic [PO_W-1:0]  px_ff, py_ff;
   logic [PF_W-1:0]  fx_ff, fy_ff;
   logic [PO_W-1:0]  pxhh_ff, pxhl_ff, pxll_ff, pyhh_ff, pyhl_ff, pyll_ff;
   logic [PF_W-1:0]  fxhh_ff, fxhl_ff, fxll_ff, fyhh_ff, fyhl_ff, fyll_ff;
   logic [SQO_W-1:0] sqx_ff, sqy_ff;
   logic [SQF_W-1:0] sqfx_ff, sqfy_ff;
   norm_type         norm_ff;

   // stall chain
   assign en[L-1] = !v_ff[L-1] || out_ready;
   for (genvar k = 0; k < L-1; k++) begin : g_en
      assign en[k] = !v_ff[k] || en[k+1];
   end

   always_comb begin
      v_in = v_ff;
      if (en[0]) begin
         v_in[0] = in_valid;
      end
      for (int k = 1; k < L; k++) begin
         if (en[k]) begin
            v_in[k] = v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // magnitudes, then scale by the coefficients
   assign mag_x = offset_x[COORD_W-1] ? (~$unsigned(offset_x) + MAG_W'(1)) : $unsigned(offset_x);
   assign mag_y = offset_y[COORD_W-1] ? (~$unsigned(offset_y) + MAG_W'(1)) : $unsigned(offset_y);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         px_ff <= PO_W'(mag_x) * PO_W'(outer_x_coef);
         py_ff <= PO_W'(mag_y) * PO_W'(outer_y_coef);
         fx_ff <= PF_W'(mag_x) * PF_W'(fade_x_coef);
         fy_ff <= PF_W'(mag_y) * PF_W'(fade_y_coef);
      end
   end

   // half-word partial products of each square
   always_ff @(posedge clock) begin
      if (en[1]) begin
         pxhh_ff <= PO_W'(px_ff[PO_W-1:OH]) * PO_W'(px_ff[PO_W-1:OH]);
         pxhl_ff <= PO_W'(px_ff[PO_W-1:OH]) * PO_W'(px_ff[OH-1:0]);
         pxll_ff <= PO_W'(px_ff[OH-1:0]) * PO_W'(px_ff[OH-1:0]);
         pyhh_ff <= PO_W'(py_ff[PO_W-1:OH]) * PO_W'(py_ff[PO_W-1:OH]);
         pyhl_ff <= PO_W'(py_ff[PO_W-1:OH]) * PO_W'(py_ff[OH-1:0]);
         pyll_ff <= PO_W'(py_ff[OH-1:0]) * PO_W'(py_ff[OH-1:0]);
         fxhh_ff <= PF_W'(fx_ff[PF_W-1:FH]) * PF_W'(fx_ff[PF_W-1:FH]);
         fxhl_ff <= PF_W'(fx_ff[PF_W-1:FH]) * PF_W'(fx_ff[FH-1:0]);
         fxll_ff <= PF_W'(fx_ff[FH-1:0]) * PF_W'(fx_ff[FH-1:0]);
         fyhh_ff <= PF_W'(fy_ff[PF_W-1:FH]) * PF_W'(fy_ff[PF_W-1:FH]);
         fyhl_ff <= PF_W'(fy_ff[PF_W-1:FH]) * PF_W'(fy_ff[FH-1:0]);
         fyll_ff <= PF_W'(fy_ff[FH-1:0]) * PF_W'(fy_ff[FH-1:0]);
      end
   end

   // assemble squares
   always_ff @(posedge clock) begin
      if (en[2]) begin
         sqx_ff  <= (SQO_W'(pxhh_ff) << (2*OH)) + (SQO_W'(pxhl_ff) << (OH+1))
                    + SQO_W'(pxll_ff);
         sqy_ff  <= (SQO_W'(pyhh_ff) << (2*OH)) + (SQO_W'(pyhl_ff) << (OH+1))
                    + SQO_W'(pyll_ff);
         sqfx_ff <= (SQF_W'(fxhh_ff) << (2*FH)) + (SQF_W'(fxhl_ff) << (FH+1))
                    + SQF_W'(fxll_ff);
         sqfy_ff <= (SQF_W'(fyhh_ff) << (2*FH)) + (SQF_W'(fyhl_ff) << (FH+1))
                    + SQF_W'(fyll_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         norm_ff.n  <= N_W'(sqx_ff) + N_W'(sqy_ff);
         norm_ff.nf <= NF_W'(sqfx_ff) + NF_W'(sqfy_ff);
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[L-1];
   assign out_data  = norm_ff;

endmodule

`default_nettype wire

// File: sv/ebfm_ratio.sv
// ----------------------------------------------------------------------------
// ebfm_ratio
// five stage band test and ramp numerator 255*n*(nf-one)/one
// ----------------------------------------------------------------------------
`default_nettype none

module ebfm_ratio #(
   parameter int COORD_FRAC_BITS = ebfm_pkg::DEF_COORD_FRAC_BITS,
   parameter int COEF_FRAC_BITS  = ebfm_pkg::DEF_COEF_FRAC_BITS
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  ebfm_pkg::norm_type in_data,
   output logic               out_valid,
   input  wire logic          out_ready,
   output ebfm_pkg::quot_type out_data
);
   import ebfm_pkg::*;

   localparam int L      = 5;
   localparam int SH     = 2 * (COORD_FRAC_BITS + COEF_FRAC_BITS);
   localparam int NB     = SH + 1;
   localparam int NCH    = 22;
   localparam int NNC    = (NB + NCH - 1) / NCH;
   localparam int NP_W   = NNC * NCH;
   localparam int NAC    = 3;
   localparam int ACH    = NF_W / NAC;
   localparam int PP_W   = NCH + ACH;
   localparam int ROW_W  = NCH + NF_W;
   localparam int NUM_W  = NP_W + NF_W;
   localparam int N255_W = NUM_W + 8;

   localparam logic [N_W-1:0]  ONE_N  = N_W'(1) << SH;
   localparam logic [NF_W-1:0] ONE_NF = NF_W'(1) << SH;

   logic [L-1:0] v_ff, v_in, en;

   band_type         band_ff [L];
   logic [NF_W-1:0]  den_ff [L];
   band_type         band_in;
   logic [NP_W-1:0]  nb_ff;
   logic [NF_W-1:0]  a_ff;
   logic [PP_W-1:0]  pp_ff [NNC][NAC];
   logic [ROW_W-1:0] row_ff [NNC];
   logic [NUM_W-1:0] num_ff, num_in;
   logic [N255_W-1:0] n255;
   logic [REM_W-1:0] rem_ff;

   assign en[L-1] = !v_ff[L-1] || out_ready;
   for (genvar k = 0; k < L-1; k++) begin : g_en
      assign en[k] = !v_ff[k] || en[k+1];
   end

   always_comb begin
      v_in = v_ff;
      if (en[0]) begin
         v_in[0] = in_valid;
      end
      for (int k = 1; k < L; k++) begin
         if (en[k]) begin
            v_in[k] = v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // band classification
   always_comb begin
      band_in.outside = in_data.n > ONE_N;
      band_in.core    = in_data.nf <= ONE_NF;
      band_in.flat    = in_data.nf <= NF_W'(in_data.n);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         band_ff[0] <= band_in;
         den_ff[0]  <= in_data.nf - NF_W'(in_data.n);
         nb_ff      <= NP_W'(in_data.n[NB-1:0]);
         a_ff       <= in_data.nf - ONE_NF;
      end
   end

   // side data follows the item
   for (genvar k = 1; k < L; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (en[k]) begin
            band_ff[k] <= band_ff[k-1];
            den_ff[k]  <= den_ff[k-1];
         end
      end
   end

   // chunk products of n and (nf - one)
   for (genvar i = 0; i < NNC; i++) begin : g_pp_i
      for (genvar j = 0; j < NAC; j++) begin : g_pp_j
         always_ff @(posedge clock) begin
            if (en[1]) begin
               pp_ff[i][j] <= PP_W'(nb_ff[i*NCH +: NCH]) * PP_W'(a_ff[j*ACH +: ACH]);
            end
         end
      end
      always_ff @(posedge clock) begin
         if (en[2]) begin
            row_ff[i] <= ROW_W'(pp_ff[i][0]) + (ROW_W'(pp_ff[i][1]) << ACH)
                         + (ROW_W'(pp_ff[i][2]) << (2*ACH));
         end
      end
   end

   always_comb begin
      num_in = '0;
      for (int i = 0; i < NNC; i++) begin
         num_in = num_in + (NUM_W'(row_ff[i]) << (i*NCH));
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         num_ff <= num_in;
      end
   end

   // times 255, scaled down by one; fits the remainder in the fade band
   assign n255 = (N255_W'(num_ff) << 8) - N255_W'(num_ff);

   always_ff @(posedge clock) begin
      if (en[4]) begin
         rem_ff <= REM_W'(n255 >> SH);
      end
   end

   assign in_ready      = en[0];
   assign out_valid     = v_ff[L-1];
   assign out_data.band = band_ff[L-1];
   assign out_data.rem  = rem_ff;
   assign out_data.den  = den_ff[L-1];

endmodule

`default_nettype wire

// File: sv/ebfm_div.sv
// ----------------------------------------------------------------------------
// ebfm_div
// eight stage restoring divider, one quotient bit a stage, and final select
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ebfm_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   output logic                             in_ready,
   input  ebfm_pkg::quot_type               in_data,
   output logic                             out_valid,
   input  wire logic                        out_ready,
   output logic [ebfm_pkg::MASK_W-1:0]      mask_value
);
   import ebfm_pkg::*;

   localparam int L    = QUOT_BITS;
   localparam int LAST = L - 1;

   logic [L-1:0] v_ff, v_in, en;

   logic [REM_W-1:0]     rem_ff [L];
   logic [NF_W-1:0]      den_ff [L];
   band_type             band_ff [L];
   logic [QUOT_BITS-1:0] q_ff [L-1];
   logic [MASK_W-1:0]    mask_ff;

   assign en[L-1] = !v_ff[L-1] || out_ready;
   for (genvar k = 0; k < L-1; k++) begin : g_en
      assign en[k] = !v_ff[k] || en[k+1];
   end

   always_comb begin
      v_in = v_ff;
      if (en[0]) begin
         v_in[0] = in_valid;
      end
      for (int k = 1; k < L; k++) begin
         if (en[k]) begin
            v_in[k] = v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   for (genvar k = 0; k < L; k++) begin : g_stage
      localparam int B = QUOT_BITS - 1 - k;

      logic [REM_W-1:0]     src_rem, shifted, rem_in;
      logic [NF_W-1:0]      src_den;
      band_type             src_band;
      logic [QUOT_BITS-1:0] src_q, q_in;
      logic                 take;

      if (k == 0) begin : g_first
         assign src_rem  = in_data.rem;
         assign src_den  = in_data.den;
         assign src_band = in_data.band;
         assign src_q    = '0;
      end else begin : g_next
         assign src_rem  = rem_ff[k-1];
         assign src_den  = den_ff[k-1];
         assign src_band = band_ff[k-1];
         assign src_q    = q_ff[k-1];
      end

      // trial subtract of the shifted divisor
      always_comb begin
         shifted = REM_W'(src_den) << B;
         take    = src_rem >= shifted;
         rem_in  = take ? (src_rem - shifted) : src_rem;
         q_in    = src_q;
         q_in[B] = take;
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= src_den;
            band_ff[k] <= src_band;
         end
      end

      if (k < LAST) begin : g_q
         always_ff @(posedge clock) begin
            if (en[k]) begin
               q_ff[k] <= q_in;
            end
         end
      end else begin : g_mask
         logic [MASK_W-1:0] mask_in;
         always_comb begin
            if (src_band.outside) begin
               mask_in = MASK_FULL;
            end else if (src_band.core) begin
               mask_in = MASK_CLEAR;
            end else if (src_band.flat) begin
               mask_in = MASK_FULL;
            end else begin
               mask_in = MASK_W'(q_in);
            end
         end
         always_ff @(posedge clock) begin
            if (en[k]) begin
               mask_ff <= mask_in;
            end
         end
      end
   end

   assign in_ready   = en[0];
   assign out_valid  = v_ff[L-1];
   assign mask_value = mask_ff;

   `EBFM_ASSERT_ALWAYS(a_reset_empties, reset |=> (v_ff == '0), "valid bits survive reset")
   `EBFM_ASSERT(a_rem_entry, (in_valid && in_ready && (in_data.band == '0)) |-> (in_data.rem < (REM_W'(in_data.den) << QUOT_BITS)), "ramp quotient above 255")
   `EBFM_ASSERT(a_rem_exit, (v_ff[LAST] && (band_ff[LAST] == '0)) |-> (rem_ff[LAST] < REM_W'(den_ff[LAST])), "division remainder not reduced")

endmodule

`default_nettype wire

// File: sv/elliptical_brush_fade_mask.sv
// pipeline: 4 norm, 5 ratio and 8 divider stages between req transfer and rsp transfer
// throughput: one pixel per cycle while rsp_ready is high; each stage holds one item and stalls only when full
// a bubble anywhere in the pipe lets a new pixel in while a result waits on rsp_ready
// reset: synchronous, clears all stage valid bits and sets all four coefficients to 2048
// csr writes are always taken; coefficients feed the first stage directly
// ----------------------------------------------------------------------------
// elliptical_brush_fade_mask
// soft elliptical brush mask: outer ellipse, solid inner core, linear fade band
// ----------------------------------------------------------------------------
`default_nettype none

module elliptical_brush_fade_mask #(
   parameter int COORD_FRAC_BITS = ebfm_pkg::DEF_COORD_FRAC_BITS,
   parameter int COEF_FRAC_BITS  = ebfm_pkg::DEF_COEF_FRAC_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // pixel offset in
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [ebfm_pkg::COORD_W-1:0] req_offset_x,
   input  wire logic signed [ebfm_pkg::COORD_W-1:0] req_offset_y,
   // mask value out
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [ebfm_pkg::MASK_W-1:0]              rsp_mask_value,
   // coefficient writes
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [ebfm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [ebfm_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ebfm_pkg::*;

   logic [OCOEF_W-1:0] outer_x_coef_ff, outer_y_coef_ff;
   logic [FCOEF_W-1:0] fade_x_coef_ff, fade_y_coef_ff;

   logic     norm_valid, norm_ready;
   norm_type norm_data;
   logic     quot_valid, quot_ready;
   quot_type quot_data;

   // coefficient registers; indexes past the list are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         outer_x_coef_ff <= RESET_OUTER_COEF;
         outer_y_coef_ff <= RESET_OUTER_COEF;
         fade_x_coef_ff  <= RESET_FADE_COEF;
         fade_y_coef_ff  <= RESET_FADE_COEF;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_OUTER_X: outer_x_coef_ff <= csr_wdata[OCOEF_W-1:0];
            REG_OUTER_Y: outer_y_coef_ff <= csr_wdata[OCOEF_W-1:0];
            REG_FADE_X:  fade_x_coef_ff  <= csr_wdata[FCOEF_W-1:0];
            REG_FADE_Y:  fade_y_coef_ff  <= csr_wdata[FCOEF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // squared norms n and nf
   ebfm_norm u_norm (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .offset_x     (req_offset_x),
      .offset_y     (req_offset_y),
      .outer_x_coef (outer_x_coef_ff),
      .outer_y_coef (outer_y_coef_ff),
      .fade_x_coef  (fade_x_coef_ff),
      .fade_y_coef  (fade_y_coef_ff),
      .out_valid    (norm_valid),
      .out_ready    (norm_ready),
      .out_data     (norm_data)
   );

   // band flags and ramp numerator over divisor nf - n
   ebfm_ratio #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS),
      .COEF_FRAC_BITS  (COEF_FRAC_BITS)
   ) u_ratio (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (norm_valid),
      .in_ready  (norm_ready),
      .in_data   (norm_data),
      .out_valid (quot_valid),
      .out_ready (quot_ready),
      .out_data  (quot_data)
   );

   // 8-bit quotient and final select; its last stage is the output register
   ebfm_div u_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (quot_valid),
      .in_ready   (quot_ready),
      .in_data    (quot_data),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .mask_value (rsp_mask_value)
   );

endmodule

`default_nettype wire

// File: tb/ebfm_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ebfm_checker
// watches the pixel, mask and coefficient channels of the fade mask block,
// predicts each mask value from its own coefficient copy and compares
// ----------------------------------------------------------------------------
`default_nettype none

module ebfm_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_ready,
   input  wire logic signed [ebfm_pkg::COORD_W-1:0] req_offset_x,
   input  wire logic signed [ebfm_pkg::COORD_W-1:0] req_offset_y,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   input  wire logic [ebfm_pkg::MASK_W-1:0]         rsp_mask_value,
   input  wire logic                                csr_valid,
   input  wire logic                                csr_ready,
   input  wire logic [ebfm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [ebfm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                       fail_count,
   output int                                       pending
);
   import ebfm_pkg::*;

   localparam int FRAC_SUM = DEF_COORD_FRAC_BITS + DEF_COEF_FRAC_BITS;

   logic [OCOEF_W-1:0] outer_x, outer_y;
   logic [FCOEF_W-1:0] fade_x, fade_y;
   logic [MASK_W-1:0]  mask_queue[$];

   function automatic logic [16:0] magnitude(logic signed [COORD_W-1:0] v);
      return v[COORD_W-1] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
   endfunction

   function automatic logic [MASK_W-1:0] predict_mask(logic signed [COORD_W-1:0] x,
                                                      logic signed [COORD_W-1:0] y);
      logic [255:0] ax, ay, px, py, n, nf, one, num, den, q;
      ax  = 256'(magnitude(x));
      ay  = 256'(magnitude(y));
      one = 256'd1 << (2 * FRAC_SUM);
      px  = ax * 256'(outer_x);
      py  = ay * 256'(outer_y);
      n   = px * px + py * py;
      px  = ax * 256'(fade_x);
      py  = ay * 256'(fade_y);
      nf  = px * px + py * py;
      if (n > one) return MASK_FULL;
      if (nf <= one) return MASK_CLEAR;
      if (nf <= n) return MASK_FULL;
      num = 256'd255 * n * (nf - one);
      den = one * (nf - n);
      q   = num / den;
      return (q > 256'd255) ? MASK_FULL : q[MASK_W-1:0];
   endfunction

   assign pending = mask_queue.size();

   initial fail_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         outer_x = RESET_OUTER_COEF;
         outer_y = RESET_OUTER_COEF;
         fade_x  = RESET_FADE_COEF;
         fade_y  = RESET_FADE_COEF;
         mask_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_OUTER_X: outer_x = csr_wdata[OCOEF_W-1:0];
               REG_OUTER_Y: outer_y = csr_wdata[OCOEF_W-1:0];
               REG_FADE_X:  fade_x  = csr_wdata;
               REG_FADE_Y:  fade_y  = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            mask_queue.push_back(predict_mask(req_offset_x, req_offset_y));
         if (rsp_valid && rsp_ready) begin
            if (mask_queue.size() == 0) begin
               $error("mask_value transfer with nothing expected: actual %0d",
                      rsp_mask_value);
               fail_count++;
            end else if (mask_queue[0] !== rsp_mask_value) begin
               $error("mask_value mismatch: expected %0d actual %0d",
                      mask_queue[0], rsp_mask_value);
               fail_count++;
               void'(mask_queue.pop_front());
            end else begin
               void'(mask_queue.pop_front());
            end
         end
      end
   end

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives pixel offsets and coefficient writes into the fade mask block under
// random stalls on both sides; the checker predicts and compares every mask
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   import ebfm_pkg::*;

   localparam int CYCLE_LIMIT  = 2000000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS  = 230;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [COORD_W-1:0]  req_offset_x = '0;
   logic signed [COORD_W-1:0]  req_offset_y = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [MASK_W-1:0]          rsp_mask_value;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;

   int  fail_count;
   int  pending;
   int  cycles = 0;
   bit  no_idle = 1'b0;   // when set neither side inserts gaps
   bit  rsp_took = 1'b0;
   int  rsp_stall = 0;

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   elliptical_brush_fade_mask DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_offset_x   (req_offset_x),
      .req_offset_y   (req_offset_y),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_mask_value (rsp_mask_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   ebfm_checker mask_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_offset_x   (req_offset_x),
      .req_offset_y   (req_offset_y),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_mask_value (rsp_mask_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   // run watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver side: after each mask transfer draw a random rsp_ready stall
   always @(posedge clock) rsp_took <= !reset && rsp_valid && rsp_ready;

   always @(negedge clock) begin
      if (rsp_took && !no_idle) rsp_stall = $urandom_range(0, 9);
      if (rsp_stall > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // one pixel transfer, preceded by a random gap
   task automatic send_pixel(input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 9);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid    <= 1'b1;
      req_offset_x <= x;
      req_offset_y <= y;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drop_valid();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic write_coef(input logic [CSR_INDEX_W-1:0] idx,
                             input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // block is idle once every predicted mask has come back
   task automatic wait_drained();
      while (pending != 0) @(posedge clock);
   endtask

   task automatic set_brush(input logic [CSR_DATA_W-1:0] ox, input logic [CSR_DATA_W-1:0] oy,
                            input logic [CSR_DATA_W-1:0] fx, input logic [CSR_DATA_W-1:0] fy);
      drop_valid();
      wait_drained();
      write_coef(REG_OUTER_X, ox);
      write_coef(REG_OUTER_Y, oy);
      write_coef(REG_FADE_X, fx);
      write_coef(REG_FADE_Y, fy);
   endtask

   // offsets mostly near the brush edge, some across the full range
   function automatic logic signed [COORD_W-1:0] pick_offset();
      case ($urandom_range(0, 7))
         0:       return '0;
         1, 2:    return COORD_W'($urandom);
         3:       return COORD_W'($signed($urandom_range(0, 128)) - 64);
         4, 5:    return COORD_W'($signed($urandom_range(0, 1024)) - 512);
         default: return COORD_W'($signed($urandom_range(0, 4096)) - 2048);
      endcase
   endfunction

   initial begin
      logic [CSR_DATA_W-1:0] ox, oy;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset coefficients: outer and fade ellipse coincide, no fade band
      send_pixel(0, 0);
      send_pixel(32767, 32767);
      send_pixel(-32768, -32768);
      send_pixel(-32768, 0);
      send_pixel(0, -32768);
      send_pixel(512, 0);
      send_pixel(513, 0);
      send_pixel(0, 512);
      send_pixel(0, -513);
      send_pixel(362, 362);
      send_pixel(1, -1);

      // core of half the radius, fade band in between; vertical axis included
      set_brush(2048, 2048, 4096, 4096);
      send_pixel(0, 300);
      send_pixel(300, 0);
      send_pixel(-400, 100);
      send_pixel(256, 0);
      send_pixel(257, 0);
      send_pixel(511, 0);
      send_pixel(512, 0);
      send_pixel(0, -384);
      send_pixel(200, -200);
      send_pixel(-300, -300);

      // out-of-list register indexes are ignored by the block
      drop_valid();
      wait_drained();
      for (int i = 4; i < 8; i++) write_coef(CSR_INDEX_W'(i), CSR_DATA_W'($urandom));

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: set_brush(2048, 4096, 8192, 6000);
            1: set_brush(0, 0, 4096, 4096);                    // degenerate outer limit
            2: set_brush(24'h3FFFF, 24'h3FFFF, 24'hFFFFFF, 24'hFFFFFF);
            3: set_brush(131072, 0, 0, 24'hFFFFFF);
            default: begin
               ox = CSR_DATA_W'($urandom_range(128, 16384));
               oy = CSR_DATA_W'($urandom_range(128, 16384));
               set_brush(ox, oy,
                         CSR_DATA_W'(ox * $urandom_range(1, 4) + $urandom_range(0, ox)),
                         CSR_DATA_W'(oy * $urandom_range(1, 4) + $urandom_range(0, oy)));
            end
         endcase
         no_idle = (ph % 3 == 2);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // in phase 4, hold off until the pipe drains once mid-phase
            if (k == PHASE_ITEMS / 2 && ph == 4) begin
               drop_valid();
               wait_drained();
            end
            send_pixel(pick_offset(), pick_offset());
         end
      end
      no_idle = 1'b0;

      drop_valid();
      wait_drained();
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire
